// ----- sv/rss_pkg.sv -----
// Shared types and constants of the running sample statistics block.
// Used by the serial arithmetic unit, the top level and the port checker.
// No dependencies.
package rss_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int KIND_WIDTH   = 2;
    localparam int SUM_WIDTH    = 32;
    localparam int SQ_WIDTH     = 48;
    localparam int PROD_WIDTH   = 64;
    localparam int DEN_WIDTH    = 2 * COUNT_WIDTH;
    localparam int VAR_WIDTH    = 31;
    localparam int SD_WIDTH     = 16;
    localparam int STEP_WIDTH   = 7;

    localparam int OUT_BITS  = COUNT_WIDTH + SAMPLE_WIDTH + VAR_WIDTH + SD_WIDTH
                               + 2 * SAMPLE_WIDTH + 1;
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [STEP_WIDTH-1:0] STEPS_SQUARE = STEP_WIDTH'(SAMPLE_WIDTH + 1);
    localparam logic [STEP_WIDTH-1:0] STEPS_COUNT  = STEP_WIDTH'(COUNT_WIDTH);
    localparam logic [STEP_WIDTH-1:0] STEPS_SUM    = STEP_WIDTH'(SUM_WIDTH);
    localparam logic [STEP_WIDTH-1:0] STEPS_DIV    = STEP_WIDTH'(PROD_WIDTH);
    localparam logic [STEP_WIDTH-1:0] STEPS_ROOT   = STEP_WIDTH'(SD_WIDTH);

    localparam logic signed [SAMPLE_WIDTH-1:0] MIN_INIT = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] MAX_INIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_REPORT = 2'd2
    } rss_kind_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } rss_op_t;

    typedef struct packed {
        logic                  start;
        rss_op_t               op;
        logic [STEP_WIDTH-1:0] steps;
    } rss_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_MEAN,
        ST_DEN,
        ST_PROD_A,
        ST_PROD_B,
        ST_VAR,
        ST_ROOT,
        ST_OUT
    } rss_state_t;

endpackage

// ----- sv/rss_serial.sv -----
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (two radicand bits) per cycle.
// Depends on rss_pkg.
module rss_serial (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rss_pkg::rss_cmd_t              cmd,
    input  logic [rss_pkg::PROD_WIDTH-1:0] opa,    // multiplicand / divisor / zero
    input  logic [rss_pkg::PROD_WIDTH-1:0] opb,    // multiplier / dividend / radicand
    output logic                           busy,
    output logic [rss_pkg::PROD_WIDTH-1:0] result
);
    import rss_pkg::*;

    localparam int PW = PROD_WIDTH;

    logic [PW-1:0]         acc_reg, acc_next;
    logic [PW-1:0]         shf_reg, shf_next;
    logic [PW-1:0]         opd_reg, opd_next;
    rss_op_t               op_reg, op_next;
    logic [STEP_WIDTH-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [PW-1:0] lhs;
    logic [PW-1:0] rhs;
    logic          sub;
    logic [PW:0]   sum_full;
    logic          ge;

    // one shared adder; in subtract mode the carry out is lhs >= rhs
    always_comb
    begin
        case (op_reg)
            OP_MUL:
            begin
                lhs = acc_reg;
                rhs = opd_reg;
                sub = 1'b0;
            end
            OP_DIV:
            begin
                lhs = {acc_reg[PW-2:0], shf_reg[PW-1]};
                rhs = opd_reg;
                sub = 1'b1;
            end
            OP_SQRT:
            begin
                lhs = {acc_reg[PW-3:0], shf_reg[PW-1:PW-2]};
                rhs = {opd_reg[PW-3:0], 2'b01};
                sub = 1'b1;
            end
            default:
            begin
                lhs = acc_reg;
                rhs = '0;
                sub = 1'b0;
            end
        endcase
        sum_full = {1'b0, lhs} + {1'b0, (sub ? ~rhs : rhs)} + {{PW{1'b0}}, sub};
        ge       = sum_full[PW];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        shf_next  = shf_reg;
        opd_next  = opd_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.start)
        begin
            acc_next  = '0;
            shf_next  = opb;
            opd_next  = opa;
            op_next   = cmd.op;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - STEP_WIDTH'(1);
            busy_next = (cnt_reg != STEP_WIDTH'(1));
            case (op_reg)
                OP_MUL:
                begin
                    if (shf_reg[0])
                    begin
                        acc_next = sum_full[PW-1:0];
                    end
                    opd_next = {opd_reg[PW-2:0], 1'b0};
                    shf_next = {1'b0, shf_reg[PW-1:1]};
                end
                OP_DIV:
                begin
                    acc_next = ge ? sum_full[PW-1:0] : lhs;
                    shf_next = {shf_reg[PW-2:0], ge};
                end
                OP_SQRT:
                begin
                    acc_next = ge ? sum_full[PW-1:0] : lhs;
                    opd_next = {opd_reg[PW-2:0], ge};
                    shf_next = {shf_reg[PW-3:0], 2'b00};
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        shf_reg <= shf_next;
        opd_reg <= opd_next;
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = acc_reg;
            OP_DIV:  result = shf_reg;
            OP_SQRT: result = opd_reg;
            default: result = acc_reg;
        endcase
    end

    assign busy = busy_reg;

endmodule

// ----- sv/running_sample_statistics_top.sv -----
// Running sample statistics: accumulators, request sequencer and output register.
// Depends on rss_pkg and rss_serial.
//
// Use: each request on the s_ channel carries a kind in s_tuser and a signed
// Q8.8 sample in s_tdata. A clear empties the accumulators; a sample is added
// to count, sum, sum of squares, minimum and maximum, or dropped with overflow set
// if the count is full; a report gives one m_ result. Kind 3 is taken and ignored.
// Sequencing: a clear or ignored request is taken at once. A sample runs the
// 17-step serial square of its magnitude. A report with count zero goes straight
// to the output; with one sample it runs only the mean divide; with two or more
// the mean divide (64 steps), two 16-step and one 32-step multiply, variance
// divide (64 steps) and 16-step square root (both skipped for zero spread), all
// on one shared adder. No request is taken while a sample or report runs.
// Reset: accumulators return to empty (min 32767, max -32768), no result is
// pending, the block is ready at once.
// Stall: a finished result waits in the output register; the block goes on
// taking clear and sample requests meanwhile, and a following report waits
// in its last step until the output register is free.
module running_sample_statistics_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rss_pkg::SAMPLE_WIDTH-1:0] s_tdata,   // [15:0] sample
    input  logic [rss_pkg::KIND_WIDTH-1:0]   s_tuser,   // [1:0] kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] sample_count, [31:16] mean_value, [62:32] variance_value,
    // [78:63] std_deviation, [94:79] minimum, [110:95] maximum, [111] overflowed
    output logic [rss_pkg::OUT_WIDTH-1:0]    m_tdata
);
    import rss_pkg::*;

    rss_state_t state_reg, state_next;

    logic        [COUNT_WIDTH-1:0]  count_reg;
    logic signed [SUM_WIDTH-1:0]    sum_reg;
    logic        [SQ_WIDTH-1:0]     sumsq_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic                           ovf_reg;

    logic [SAMPLE_WIDTH-1:0] mean_reg;
    logic [DEN_WIDTH-1:0]    den_reg;
    logic [PROD_WIDTH-1:0]   a_reg;
    logic [VAR_WIDTH-1:0]    var_reg;
    logic [SD_WIDTH-1:0]     sd_reg;
    logic                    out_valid_reg;
    logic [OUT_WIDTH-1:0]    out_data_reg;

    rss_cmd_t              cmd;
    logic [PROD_WIDTH-1:0] opa;
    logic [PROD_WIDTH-1:0] opb;
    logic                  busy;
    logic [PROD_WIDTH-1:0] result;

    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] in_sample;
    logic [SAMPLE_WIDTH:0]          sample_ext;
    logic [SAMPLE_WIDTH:0]          sample_mag;
    logic [SUM_WIDTH-1:0]           sum_mag;
    logic                           count_full;
    logic                           count_small;
    logic                           out_free;
    logic [SAMPLE_WIDTH-1:0]        mean_q;
    logic [SAMPLE_WIDTH-1:0]        mean_val;
    logic [VAR_WIDTH-1:0]           var_sat;
    logic                           a_gt_b;

    rss_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa),
        .opb    (opb),
        .busy   (busy),
        .result (result)
    );

    assign accept      = s_tvalid && s_tready;
    assign in_sample   = signed'(s_tdata);
    assign sample_ext  = {s_tdata[SAMPLE_WIDTH-1], s_tdata};
    assign sample_mag  = sample_ext[SAMPLE_WIDTH] ? (~sample_ext + 1'b1) : sample_ext;
    assign sum_mag     = sum_reg[SUM_WIDTH-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign count_full  = &count_reg;
    assign count_small = (count_reg[COUNT_WIDTH-1:1] == '0);
    assign out_free    = !out_valid_reg || m_tready;
    assign mean_q      = result[SAMPLE_WIDTH-1:0];
    assign mean_val    = sum_reg[SUM_WIDTH-1] ? (~mean_q + 1'b1) : mean_q;
    assign var_sat     = (|result[PROD_WIDTH-1:VAR_WIDTH]) ? {VAR_WIDTH{1'b1}}
                                                           : result[VAR_WIDTH-1:0];
    assign a_gt_b      = (a_reg > result);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == KIND_SAMPLE && !count_full)
                    begin
                        state_next = ST_SQUARE;
                    end
                    else if (s_tuser == KIND_REPORT)
                    begin
                        state_next = (count_reg == '0) ? ST_OUT : ST_MEAN;
                    end
                end
            end
            ST_SQUARE: if (!busy) state_next = ST_IDLE;
            ST_MEAN:   if (!busy) state_next = count_small ? ST_OUT : ST_DEN;
            ST_DEN:    if (!busy) state_next = ST_PROD_A;
            ST_PROD_A: if (!busy) state_next = ST_PROD_B;
            ST_PROD_B: if (!busy) state_next = a_gt_b ? ST_VAR : ST_OUT;
            ST_VAR:    if (!busy) state_next = ST_ROOT;
            ST_ROOT:   if (!busy) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // issue the next serial operation as the previous one finishes
    always_comb
    begin
        s_tready  = 1'b0;
        cmd.start = 1'b0;
        cmd.op    = OP_MUL;
        cmd.steps = '0;
        opa       = '0;
        opb       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == KIND_SAMPLE && !count_full)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_MUL;
                    cmd.steps = STEPS_SQUARE;
                    opa       = PROD_WIDTH'(sample_mag);
                    opb       = PROD_WIDTH'(sample_mag);
                end
                else if (s_tvalid && s_tuser == KIND_REPORT && count_reg != '0)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_DIV;
                    cmd.steps = STEPS_DIV;
                    opa       = PROD_WIDTH'(count_reg);
                    opb       = PROD_WIDTH'(sum_mag);
                end
            end
            ST_MEAN:
            begin
                if (!busy && !count_small)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_MUL;
                    cmd.steps = STEPS_COUNT;
                    opa       = PROD_WIDTH'(count_reg);
                    opb       = PROD_WIDTH'(count_reg - 1'b1);
                end
            end
            ST_DEN:
            begin
                if (!busy)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_MUL;
                    cmd.steps = STEPS_COUNT;
                    opa       = PROD_WIDTH'(sumsq_reg);
                    opb       = PROD_WIDTH'(count_reg);
                end
            end
            ST_PROD_A:
            begin
                if (!busy)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_MUL;
                    cmd.steps = STEPS_SUM;
                    opa       = PROD_WIDTH'(sum_mag);
                    opb       = PROD_WIDTH'(sum_mag);
                end
            end
            ST_PROD_B:
            begin
                if (!busy && a_gt_b)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_DIV;
                    cmd.steps = STEPS_DIV;
                    opa       = PROD_WIDTH'(den_reg);
                    opb       = a_reg - result;
                end
            end
            ST_VAR:
            begin
                if (!busy)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_SQRT;
                    cmd.steps = STEPS_ROOT;
                    opb       = {1'b0, var_sat, {(PROD_WIDTH-VAR_WIDTH-1){1'b0}}};
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            min_reg   <= MIN_INIT;
            max_reg   <= MAX_INIT;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                case (s_tuser)
                    KIND_CLEAR:
                    begin
                        count_reg <= '0;
                        sum_reg   <= '0;
                        sumsq_reg <= '0;
                        min_reg   <= MIN_INIT;
                        max_reg   <= MAX_INIT;
                        ovf_reg   <= 1'b0;
                    end
                    KIND_SAMPLE:
                    begin
                        if (count_full)
                        begin
                            ovf_reg <= 1'b1;    // drop the sample
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                            sum_reg   <= sum_reg + {{(SUM_WIDTH-SAMPLE_WIDTH)
                                                     {s_tdata[SAMPLE_WIDTH-1]}}, s_tdata};
                            if (in_sample < min_reg)
                            begin
                                min_reg <= in_sample;
                            end
                            if (in_sample > max_reg)
                            begin
                                max_reg <= in_sample;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_SQUARE && !busy)
            begin
                sumsq_reg <= sumsq_reg + result[SQ_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && s_tuser == KIND_REPORT)
        begin
            mean_reg <= '0;
            var_reg  <= '0;
            sd_reg   <= '0;
        end
        if (state_reg == ST_MEAN && !busy)
        begin
            mean_reg <= mean_val;
        end
        if (state_reg == ST_DEN && !busy)
        begin
            den_reg <= result[DEN_WIDTH-1:0];
        end
        if (state_reg == ST_PROD_A && !busy)
        begin
            a_reg <= result;
        end
        if (state_reg == ST_VAR && !busy)
        begin
            var_reg <= var_sat;
        end
        if (state_reg == ST_ROOT && !busy)
        begin
            sd_reg <= result[SD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg <= OUT_WIDTH'({ovf_reg, max_reg, min_reg, sd_reg, var_reg,
                                        mean_reg, count_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/rss_checker.sv -----
// Port-level checks of the running sample statistics block, bound to the top level.
// Depends on rss_pkg.
module rss_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [rss_pkg::SAMPLE_WIDTH-1:0] s_tdata,
    input logic [rss_pkg::KIND_WIDTH-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rss_pkg::OUT_WIDTH-1:0]    m_tdata
);
    import rss_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // a report keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_REPORT |=> !s_tready)
    else $error("request taken during a report");

    // fewer than two samples give no spread
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:1] == '0 |-> m_tdata[62:32] == '0 && m_tdata[78:63] == '0)
    else $error("nonzero variance below two samples");

    // empty accumulators report the empty markers and zero mean
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:0] == '0 |->
        m_tdata[31:16] == '0 && m_tdata[94:79] == MIN_INIT && m_tdata[110:95] == MAX_INIT)
    else $error("empty result fields wrong");

    // with samples present the minimum never exceeds the maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:0] != '0 |-> $signed(m_tdata[94:79]) <= $signed(m_tdata[110:95]))
    else $error("minimum above maximum");

endmodule

bind running_sample_statistics_top rss_checker u_rss_checker (.*);

// ----- sim/tb_running_sample_statistics_top.sv -----
// Self-checking bench for the running sample statistics block: drives clear, sample and
// report requests with random bursts and gaps, and checks every report field against a
// bit-accurate statistics predictor. Depends on rss_pkg and running_sample_statistics_top.
module tb_running_sample_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    localparam logic [KIND_WIDTH-1:0] KIND_RESERVED = 2'd3;
    localparam int unsigned COUNT_FULL     = (1 << COUNT_WIDTH) - 1;
    localparam int          RANDOM_ITEMS   = 550;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          MAX_SHOWN      = 10;

    typedef struct {
        logic [15:0]        n;
        logic signed [15:0] mean;
        logic [30:0]        variance;
        logic [15:0]        std_dev;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic               dropped;
    } stats_report_t;

    class stats_scoreboard;
        int unsigned        n_samples;
        int                 sum_acc;
        logic [47:0]        sq_acc;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        bit                 dropped;
        stats_report_t      expected_q[$];
        int unsigned        mismatches;

        function new();
            mismatches = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            n_samples = 0;
            sum_acc   = 0;
            sq_acc    = '0;
            lo        = MIN_INIT;
            hi        = MAX_INIT;
            dropped   = 1'b0;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 16; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void note_request(logic [KIND_WIDTH-1:0] kind, logic [SAMPLE_WIDTH-1:0] raw);
            longint             sv;
            longint             sq;
            longint             mean_q;
            longint unsigned    mag;
            longint unsigned    a;
            longint unsigned    b;
            longint unsigned    den;
            longint unsigned    var_q;
            longint unsigned    sd_q;
            logic signed [15:0] s;
            stats_report_t      r;
            s  = raw;
            sv = s;
            case (kind)
                KIND_CLEAR:
                    clear_stats();
                KIND_SAMPLE:
                begin
                    if (n_samples >= COUNT_FULL)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        n_samples++;
                        sum_acc = sum_acc + int'(sv);
                        sq      = sv * sv;
                        sq_acc  = sq_acc + sq[47:0];
                        if (s < lo)
                            lo = s;
                        if (s > hi)
                            hi = s;
                    end
                end
                KIND_REPORT:
                begin
                    mean_q = 0;
                    var_q  = 0;
                    if (n_samples > 0)
                        mean_q = longint'(sum_acc) / longint'(n_samples);
                    if (n_samples > 1)
                    begin
                        mag = (sum_acc < 0) ? -longint'(sum_acc) : longint'(sum_acc);
                        a   = n_samples;
                        a   = a * sq_acc;
                        b   = mag * mag;
                        den = n_samples;
                        den = den * (n_samples - 1);
                        if (a > b && den != 0)
                            var_q = (a - b) / den;
                        if (var_q > 64'h7FFF_FFFF)
                            var_q = 64'h7FFF_FFFF;
                    end
                    sd_q = floor_sqrt(var_q);
                    if (sd_q > 64'hFFFF)
                        sd_q = 64'hFFFF;
                    r.n        = n_samples[15:0];
                    r.mean     = mean_q[15:0];
                    r.variance = var_q[30:0];
                    r.std_dev  = sd_q[15:0];
                    r.lo       = lo;
                    r.hi       = hi;
                    r.dropped  = dropped;
                    expected_q.push_back(r);
                end
                default:
                    ;   // reserved kind: no effect
            endcase
        endfunction

        function void check_field(string label, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("mismatch %s: expected %0h got %0h", label, want, got);
            end
        endfunction

        function void check_report(logic [OUT_WIDTH-1:0] d);
            stats_report_t r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected report: %h", d);
                return;
            end
            r = expected_q.pop_front();
            // compare raw field bits, so signed fields are not sign-extended
            check_field("sample_count",   r.n,          d[15:0]);
            check_field("mean_value",     r.mean[15:0], d[31:16]);
            check_field("variance_value", r.variance,   d[62:32]);
            check_field("std_deviation",  r.std_dev,    d[78:63]);
            check_field("minimum",        r.lo[15:0],   d[94:79]);
            check_field("maximum",        r.hi[15:0],   d[110:95]);
            check_field("overflowed",     r.dropped,    d[111]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [SAMPLE_WIDTH-1:0] s_tdata  = '0;
    logic [KIND_WIDTH-1:0]   s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_WIDTH-1:0]    m_tdata;

    stats_scoreboard sb;
    int  burst_left    = 0;
    bit  steady_sender = 1'b0;
    int  issued        = 0;
    int  stall_mode    = 0;
    int  stall_left    = 0;
    int  stall_phase   = 0;
    int  quiet_cycles  = 0;

    running_sample_statistics_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: switch between stall patterns at random intervals.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = ($urandom_range(0, 3) != 0);
            2:       m_tready = ($urandom_range(0, 3) == 0);
            default: m_tready = ((stall_phase % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_report(m_tdata);
        if (s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [KIND_WIDTH-1:0] kind,
                                input logic [SAMPLE_WIDTH-1:0] value);
        int gap;
        if (!steady_sender && burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata  = SAMPLE_WIDTH'($urandom);
            s_tuser  = KIND_WIDTH'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = value;
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        if (kind != KIND_RESERVED)
            issued++;
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_value(int style, logic [15:0] base);
        case (style)
            0:       return SAMPLE_WIDTH'($urandom);
            1:       return 16'($urandom_range(0, 511) - 256);
            2:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            3:       return base;   // constant run: zero variance
            default: return base + 16'($urandom_range(0, 63) - 32);
        endcase
    endfunction

    task automatic run_random();
        int          choice;
        int          len;
        int          style;
        logic [15:0] base;
        while (issued < RANDOM_ITEMS)
        begin
            choice        = $urandom_range(0, 9);
            steady_sender = ($urandom_range(0, 3) == 0);
            if (choice == 0)
            begin
                send_request(KIND_CLEAR, SAMPLE_WIDTH'($urandom));
            end
            else if (choice == 1)
            begin
                send_request(KIND_RESERVED, SAMPLE_WIDTH'($urandom));
            end
            else if (choice == 2)
            begin
                send_request(KIND_REPORT, SAMPLE_WIDTH'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    send_request(KIND_CLEAR, SAMPLE_WIDTH'($urandom));
                len   = $urandom_range(0, 20);
                style = $urandom_range(0, 4);
                base  = 16'($urandom);
                for (int i = 0; i < len; i++)
                begin
                    send_request(KIND_SAMPLE, pick_value(style, base));
                    if ($urandom_range(0, 7) == 0)
                        send_request(KIND_REPORT, SAMPLE_WIDTH'($urandom));
                end
                send_request(KIND_REPORT, SAMPLE_WIDTH'($urandom));
            end
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty accumulators, then single and two extreme samples.
        send_request(KIND_REPORT, 16'h0000);
        send_request(KIND_SAMPLE, 16'h7FFF);
        send_request(KIND_REPORT, 16'hFFFF);
        send_request(KIND_SAMPLE, 16'h8000);
        send_request(KIND_REPORT, 16'h0000);
        // Reserved kind must leave the statistics alone.
        send_request(KIND_RESERVED, 16'h1234);
        send_request(KIND_REPORT, 16'h0000);
        send_request(KIND_CLEAR, 16'hFFFF);
        send_request(KIND_REPORT, 16'h0000);
        // Negative mean truncates toward zero.
        send_request(KIND_SAMPLE, 16'hFFFD);
        send_request(KIND_SAMPLE, 16'hFFFE);
        send_request(KIND_REPORT, 16'h0000);
        send_request(KIND_CLEAR, 16'h0000);
        send_request(KIND_SAMPLE, 16'h5555);
        send_request(KIND_SAMPLE, 16'hAAAA);
        send_request(KIND_SAMPLE, 16'h0000);
        send_request(KIND_SAMPLE, 16'hFFFF);
        send_request(KIND_REPORT, 16'h0000);
        send_request(KIND_REPORT, 16'h0000);

        // Back-to-back requests with no idle cycles between them.
        steady_sender = 1'b1;
        send_request(KIND_CLEAR, 16'h0000);
        send_request(KIND_REPORT, 16'h0000);
        send_request(KIND_SAMPLE, 16'h8000);
        send_request(KIND_SAMPLE, 16'h7FFF);
        send_request(KIND_RESERVED, 16'h8000);
        send_request(KIND_REPORT, 16'h0000);
        send_request(KIND_CLEAR, 16'h0000);
        send_request(KIND_REPORT, 16'h0000);
        steady_sender = 1'b0;

        issued = 0;
        run_random();

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rss_pkg.sv
sv/rss_serial.sv
sv/running_sample_statistics_top.sv
sv/rss_checker.sv
sim/tb_running_sample_statistics_top.sv
